FILE: rtl/me_pkg.sv
// Shared widths, types and constants for the modular exponentiation block.
// No dependencies; every other file imports this package.
package me_pkg;

   localparam int MOD_W = 31;
   localparam int EXP_W = 63;

   typedef logic [MOD_W-1:0] mod_type;
   typedef logic [EXP_W-1:0] exp_type;

   // reset modulus: ten to the ninth plus seven
   localparam mod_type MOD_RESET = MOD_W'(1000000007);
   localparam mod_type MOD_ONE   = MOD_W'(1);

endpackage

FILE: rtl/me_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on me_pkg for the payload types.
interface me_req_if import me_pkg::*; ();
   logic    valid;
   logic    ready;
   mod_type base;
   exp_type exponent;

   modport source (output valid, base, exponent, input ready);
   modport sink   (input valid, base, exponent, output ready);
endinterface

interface me_rsp_if import me_pkg::*; ();
   logic    valid;
   logic    ready;
   mod_type power;

   modport source (output valid, power, input ready);
   modport sink   (input valid, power, output ready);
endinterface

FILE: rtl/me_modmul.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on me_pkg. Requires opnd_y < modulus and modulus >= 2.
module me_modmul import me_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  mod_type opnd_x,
   input  mod_type opnd_y,
   input  mod_type modulus,
   output logic    done,
   output mod_type product
);

   localparam int CNT_W = $clog2(MOD_W + 1);

   logic             busy_ff,  busy_in;
   logic             done_ff,  done_in;
   logic [CNT_W-1:0] cnt_ff,   cnt_in;
   mod_type          xsh_ff,   xsh_in;
   mod_type          y_ff,     y_in;
   mod_type          r_ff,     r_in;

   logic [MOD_W:0]   dbl;
   logic [MOD_W:0]   dbl_red;
   logic [MOD_W:0]   sum;
   logic [MOD_W:0]   sum_red;
   logic [MOD_W:0]   mod_ext;

   // one interleaved step: r = (2r + bit*y) mod m, each half kept below m
   always_comb begin
      mod_ext = {1'b0, modulus};
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
      sum     = dbl_red + (xsh_ff[MOD_W-1] ? {1'b0, y_ff} : '0);
      sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
   end

   // load on start, otherwise advance one bit while busy
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      xsh_in  = xsh_ff;
      y_in    = y_ff;
      r_in    = r_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(MOD_W);
         xsh_in  = opnd_x;
         y_in    = opnd_y;
         r_in    = '0;
      end else if (busy_ff) begin
         r_in   = sum_red[MOD_W-1:0];
         xsh_in = {xsh_ff[MOD_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath needs no reset
   always_ff @(posedge clock) begin
      xsh_ff <= xsh_in;
      y_ff   <= y_in;
      r_ff   <= r_in;
   end

   assign done    = done_ff;
   assign product = r_ff;

endmodule

FILE: rtl/modular_exponentiation_top.sv
// Top level of the modular exponentiation block: sequencer, csr and two multipliers.
// Depends on me_pkg, me_if and me_modmul.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+---------------------------
//   req_bus  | in  | valid / ready      | base[30:0], exponent[62:0]
//   rsp_bus  | out | valid / ready      | power[30:0]
//   csr_*    | in  | csr_wr_en          | csr_wr_data[30:0] modulus
//
// One item at a time. From request beat to response valid, the base is
// reduced first; then each exponent bit up to the highest set bit (at most
// EXP_BITS) takes a launch and one pass of the bit-serial multipliers,
// square and multiply running side by side; S_DONE then hands the result back.
// Modulus 0 or 1 answers 0. Reset sets the modulus to 1000000007.
// A stalled response is held while the next request is already taken; the
// next result then waits in its final state until the held beat is taken.
module modular_exponentiation_top import me_pkg::*; #(
   parameter int EXP_BITS = 63
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_wr_en,
   input  mod_type   csr_wr_data,
   me_req_if.sink    req_bus,
   me_rsp_if.source  rsp_bus
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_REDUCE = 3'd1;
   localparam logic [2:0] S_LAUNCH = 3'd2;
   localparam logic [2:0] S_STEP   = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]          state_ff, state_in;
   mod_type             mod_ff;
   mod_type             acc_ff,   acc_in;
   mod_type             pw_ff,    pw_in;
   logic [EXP_BITS-1:0] exp_ff,   exp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   mod_type             rsp_power_ff, rsp_power_in;

   logic    req_beat;
   logic    mod_ok;
   logic    start_a, start_b;
   mod_type xa, ya;
   logic    done_a, done_b;
   mod_type prod_a, prod_b;
   logic [EXP_BITS-1:0] exp_next;

   assign req_beat = req_bus.valid && req_bus.ready;
   assign mod_ok   = (mod_ff > MOD_ONE);
   assign exp_next = exp_ff >> 1;

   // unit A reduces the base first, then multiplies acc by the power
   assign start_a = (state_ff == S_IDLE && req_beat && mod_ok) || (state_ff == S_LAUNCH);
   assign start_b = (state_ff == S_LAUNCH);
   assign xa      = (state_ff == S_IDLE) ? req_bus.base : acc_ff;
   assign ya      = (state_ff == S_IDLE) ? MOD_ONE : pw_ff;

   me_modmul u_mul_a (
      .clock   (clock),
      .reset   (reset),
      .start   (start_a),
      .opnd_x  (xa),
      .opnd_y  (ya),
      .modulus (mod_ff),
      .done    (done_a),
      .product (prod_a)
   );

   // unit B squares the running power
   me_modmul u_mul_b (
      .clock   (clock),
      .reset   (reset),
      .start   (start_b),
      .opnd_x  (pw_ff),
      .opnd_y  (pw_ff),
      .modulus (mod_ff),
      .done    (done_b),
      .product (prod_b)
   );

   // sequence reduce, then one launch/step pair per exponent bit
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      pw_in        = pw_ff;
      exp_in       = exp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_power_in = rsp_power_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               exp_in = req_bus.exponent[EXP_BITS-1:0];
               if (mod_ok) begin
                  acc_in   = MOD_ONE;
                  state_in = S_REDUCE;
               end else begin
                  acc_in   = '0;
                  state_in = S_DONE;
               end
            end
         end
         S_REDUCE: begin
            if (done_a) begin
               pw_in    = prod_a;
               state_in = (exp_ff == '0) ? S_DONE : S_LAUNCH;
            end
         end
         S_LAUNCH: begin
            state_in = S_STEP;
         end
         S_STEP: begin
            if (done_a && done_b) begin
               if (exp_ff[0]) begin
                  acc_in = prod_a;
               end
               pw_in    = prod_b;
               exp_in   = exp_next;
               state_in = (exp_next == '0) ? S_DONE : S_LAUNCH;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_power_in = acc_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state and the modulus register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mod_ff       <= MOD_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mod_ff <= csr_wr_data;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      pw_ff        <= pw_in;
      exp_ff       <= exp_in;
      rsp_power_ff <= rsp_power_in;
   end

   assign req_bus.ready = (state_ff == S_IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.power = rsp_power_ff;

endmodule

FILE: rtl/me_checker.sv
// Port-level checks for the modular exponentiation top, bound to every instance.
// Depends on me_pkg; sees only the top level's ports.
module me_checker import me_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    csr_wr_en,
   input mod_type csr_wr_data,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input mod_type rsp_power
);

   mod_type mod_ff;

   // track the modulus as written through the csr port
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MOD_RESET;
      end else if (csr_wr_en) begin
         mod_ff <= csr_wr_data;
      end
   end

   // hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_power))
      else $error("response beat changed while stalled");

   // every result is reduced below the modulus, checked while the modulus is above one
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mod_ff > MOD_ONE |-> rsp_power < mod_ff)
      else $error("result not below modulus");

   // one item at a time: no request taken right after another
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // nothing to deliver just after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind modular_exponentiation_top me_checker u_me_checker (
   .clock       (clock),
   .reset       (reset),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_power   (rsp_bus.power)
);

FILE: tb/modular_exponentiation_top_tb.sv
// Self-checking testbench for modular_exponentiation_top: directed table, then random beats
// under several idle/stall mixes, each checked against a hand-worked answer or a square-and-multiply predictor.
// Depends on me_pkg, me_if and the RTL of the block.
module modular_exponentiation_top_tb import me_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD         = 8;
   localparam int RESET_CYCLES       = 4;
   localparam int CYCLE_LIMIT        = 8_000_000;
   localparam int TAIL_CYCLES        = 2200;
   localparam int HOLD_CYCLES        = 1500;
   localparam int PRESSURE_BEATS     = 10;
   localparam int PHASES             = 4;
   localparam int SETTINGS_PER_PHASE = 5;
   localparam int BEATS_PER_SETTING  = 41;
   localparam int N_DIRECTED         = 25;

   localparam mod_type MOD_MAX  = 31'h7FFF_FFFF;
   localparam mod_type MOD_TWO  = 31'd2;
   localparam mod_type MOD_ZERO = 31'd0;
   localparam exp_type EXP_ONES = 63'h7FFF_FFFF_FFFF_FFFF;

   // one directed beat: modulus to run under, operands, and an optional hand-worked answer
   typedef struct packed {
      mod_type modulus;
      mod_type base;
      exp_type exponent;
      logic    typed;
      mod_type power;
   } vec_row;

   logic    clock;
   logic    reset;
   logic    csr_wr_en;
   mod_type csr_wr_data;

   me_req_if req_bus ();
   me_rsp_if rsp_bus ();

   mod_type cur_modulus;
   mod_type expected_powers[$];
   mod_type want_power;
   int      send_idle_pct;
   int      recv_stall_pct;
   logic    hold_req;
   int      fail_count;
   int      sent_count;
   int      checked_count;
   int      modulus_writes;
   longint  cycle_count;

   vec_row directed_rows [N_DIRECTED] = '{
      '{MOD_RESET, 31'd5,          63'd0,        1'b1, 31'd1},
      '{MOD_RESET, 31'd0,          63'd0,        1'b1, 31'd1},
      '{MOD_RESET, 31'd0,          63'd7,        1'b1, 31'd0},
      '{MOD_RESET, 31'd1,          EXP_ONES,     1'b1, 31'd1},
      '{MOD_RESET, 31'd2,          63'd10,       1'b1, 31'd1024},
      '{MOD_RESET, 31'd3,          63'd5,        1'b1, 31'd243},
      '{MOD_RESET, MOD_MAX,        63'd1,        1'b1, 31'd147483633},
      '{MOD_RESET, 31'd1000000007, 63'd3,        1'b1, 31'd0},
      '{MOD_RESET, 31'd1000000008, 63'd9,        1'b1, 31'd1},
      '{MOD_RESET, 31'd1000000006, 63'd2,        1'b1, 31'd1},
      '{MOD_RESET, 31'd1000000006, EXP_ONES,     1'b1, 31'd1000000006},
      '{MOD_RESET, 31'd2,          63'd1000000006, 1'b1, 31'd1},
      '{MOD_RESET, MOD_MAX,        63'h4000_0000_0000_0000, 1'b0, 31'd0},
      '{MOD_RESET, 31'd12345,      63'h5555_5555_5555_5555, 1'b0, 31'd0},
      '{MOD_RESET, 31'h2AAA_AAAA,  63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 31'd0},
      '{MOD_TWO,   31'd3,          63'd7,        1'b1, 31'd1},
      '{MOD_TWO,   31'h7FFF_FFFE,  63'd0,        1'b1, 31'd1},
      '{MOD_MAX,   31'h7FFF_FFFE,  63'd3,        1'b1, 31'h7FFF_FFFE},
      '{MOD_MAX,   MOD_MAX,        63'd5,        1'b1, 31'd0},
      '{MOD_MAX,   31'd16807,      63'h1234_5678_9ABC_DEF0, 1'b0, 31'd0},
      '{MOD_ONE,   31'd7,          63'd0,        1'b1, 31'd0},
      '{MOD_ONE,   MOD_MAX,        EXP_ONES,     1'b1, 31'd0},
      '{MOD_ZERO,  31'd5,          63'd3,        1'b1, 31'd0},
      '{MOD_ZERO,  31'd0,          63'd0,        1'b1, 31'd0},
      '{MOD_RESET, 31'd7,          63'd1,        1'b1, 31'd7}
   };

   modular_exponentiation_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   // base to the exponent modulo the modulus, right-to-left over every exponent bit
   function automatic mod_type expected_power(mod_type modulus, mod_type base, exp_type exponent);
      longint unsigned m;
      longint unsigned square;
      longint unsigned acc;
      m = modulus;
      if (m == 0) begin
         return '0;
      end
      square = base % m;
      acc    = 1 % m;
      for (int i = 0; i < EXP_W; i++) begin
         if (exponent[i]) begin
            acc = (acc * square) % m;
         end
         square = (square * square) % m;
      end
      return mod_type'(acc);
   endfunction

   // drop valid and hold until every expected power has come back
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_powers.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // write the modulus register while nothing is in flight
   task automatic write_modulus(mod_type value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cur_modulus = value;
      modulus_writes++;
   endtask

   // offer one request beat after a random gap; record its power once accepted
   task automatic send_request(mod_type base, exp_type exponent, logic typed, mod_type power);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.base     <= base;
      req_bus.exponent <= exponent;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      expected_powers.push_back(typed ? power : expected_power(cur_modulus, base, exponent));
      sent_count++;
      @(negedge clock);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // cycle limit
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("modular_exponentiation_top_tb failed");
            $finish;
         end
      end
   end

   // response side: random stalls, plus a long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req      <= 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_bus.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // check each response beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_powers.size() == 0) begin
            $error("power: beat with nothing expected, actual %0d", rsp_bus.power);
            fail_count++;
         end else begin
            want_power = expected_powers.pop_front();
            checked_count++;
            if (rsp_bus.power !== want_power) begin
               $error("power mismatch: expected %0d, actual %0d", want_power, rsp_bus.power);
               fail_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      mod_type base;
      exp_type exponent;
      mod_type new_mod;
      int      setting_idx;
      int      width;

      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_bus.valid    = 1'b0;
      req_bus.base     = '0;
      req_bus.exponent = '0;
      hold_req         = 1'b0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      fail_count       = 0;
      sent_count       = 0;
      checked_count    = 0;
      modulus_writes   = 0;
      setting_idx      = 0;
      cur_modulus      = MOD_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table, starting on the reset modulus
      foreach (directed_rows[i]) begin
         if (directed_rows[i].modulus !== cur_modulus) begin
            write_modulus(directed_rows[i].modulus);
         end
         send_request(directed_rows[i].base, directed_rows[i].exponent,
                      directed_rows[i].typed, directed_rows[i].power);
      end

      // random beats under each idle/stall mix, changing the modulus a few times per mix
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               send_idle_pct = 0;  recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 65; recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;  recv_stall_pct = 65;
            end
            default: begin
               send_idle_pct = 30; recv_stall_pct = 30;
            end
         endcase
         for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
            case (setting_idx)
               0: new_mod = MOD_MAX;
               1: new_mod = MOD_TWO;
               2: new_mod = MOD_RESET;
               default: begin
                  case ($urandom_range(4))
                     0: new_mod = MOD_MAX;
                     1: new_mod = mod_type'($urandom_range(1000, 2));
                     2: new_mod = MOD_RESET;
                     default: new_mod = mod_type'($urandom_range(32'h7FFF_FFFF, 2));
                  endcase
               end
            endcase
            setting_idx++;
            write_modulus(new_mod);
            for (int n = 0; n < BEATS_PER_SETTING; n++) begin
               case ($urandom_range(9))
                  0: base = mod_type'($urandom_range(1));
                  1: base = cur_modulus - MOD_ONE;
                  2, 3, 4: base = mod_type'($urandom_range(32'(cur_modulus) - 1, 0));
                  default: base = mod_type'($urandom);
               endcase
               // mostly short exponents keep the run short; a few use all bits
               case ($urandom_range(99)) inside
                  [0:59]: begin
                     width    = $urandom_range(12, 1);
                     exponent = exp_type'($urandom) & ((exp_type'(1) << width) - 1);
                  end
                  [60:84]: exponent = exp_type'($urandom);
                  [85:91]: exponent = exp_type'($urandom_range(3));
                  default: exponent = exp_type'({$urandom, $urandom});
               endcase
               send_request(base, exponent, 1'b0, '0);
            end
         end
      end

      // hold the response side off so the block backs up, then drain completely
      wait_idle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_req <= 1'b1;
      for (int n = 0; n < PRESSURE_BEATS; n++) begin
         send_request(mod_type'($urandom), exp_type'($urandom_range(15)), 1'b0, '0);
      end
      wait_idle();

      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d requests (%0d directed) over %0d modulus writes; %0d responses checked",
               sent_count, N_DIRECTED, modulus_writes, checked_count);
      if (fail_count == 0 && expected_powers.size() == 0) begin
         $display("modular_exponentiation_top_tb passed");
      end else begin
         $display("modular_exponentiation_top_tb failed");
      end
      $finish;
   end

endmodule
